// ===== sv/psr_pkg.sv =====
// Shared types, constants and a lookup table for the pump speed ramp controller.
// No dependencies; every other file imports this package.
package psr_pkg;

    localparam int DAC_BITS = 12;
    localparam logic [DAC_BITS-1:0] DAC_MAX = '1;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TGT_W   = 12;
    localparam int PCT_W   = 7;
    localparam int DEN_W   = 13;
    localparam int QUO_W   = 12;
    localparam int PROD_W  = DEN_W + QUO_W;
    localparam int EXT_W   = 17;
    localparam int FLOW_W  = 18;
    localparam int FLOW_FULL_W = 26;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam int FULL_SCALE = 32'hfff;
    localparam int PCT_MAX    = 100;
    localparam int PCT_TAB_N  = 128;
    localparam logic [PCT_W-1:0]  PCT_LIMIT = 7'd100;
    localparam logic [DEN_W-1:0]  DEG_SCALE = 13'd100;
    localparam logic [FLOW_FULL_W-1:0] FLOW_PER_PULSE = 26'd600;
    localparam logic [FLOW_W-1:0] FLOW_MAX = 18'h3FFFF;

    localparam logic [6:0]  SPEED_LOW_RST  = 7'd20;
    localparam logic [6:0]  SPEED_HIGH_RST = 7'd50;
    localparam logic [5:0]  TEMP_LOW_RST   = 6'd25;
    localparam logic [5:0]  TEMP_HIGH_RST  = 6'd40;
    localparam logic [12:0] CUR_LIMIT_RST  = 13'd0;
    localparam logic [15:0] ARM_DELAY_RST  = 16'd3000;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_LOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_HIGH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_LOW   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_HIGH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CUR_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ARM_DELAY  = 3'd5;

    typedef logic [TGT_W-1:0] t_pct_tab [PCT_TAB_N];

    function automatic t_pct_tab build_pct_tab();
        t_pct_tab tab;
        for (int i = 0; i < PCT_TAB_N; i++) begin
            tab[i] = TGT_W'((i * FULL_SCALE) / PCT_MAX);
        end
        return tab;
    endfunction

    localparam t_pct_tab PCT_TO_DAC = build_pct_tab();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_DAC,
        ST_DIV_DAC,
        ST_MUL_PCT,
        ST_DIV_PCT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul_dac;
        logic mul_pct;
        logic div_step;
        logic commit;
    } t_cmd;

endpackage

// ===== sv/psr_div.sv =====
// Restoring divider, one quotient bit per step, for the ramp interpolation.
// Depends on psr_pkg for widths.
module psr_div (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic [psr_pkg::PROD_W-1:0]   i_dividend,
    input  logic [psr_pkg::DEN_W-1:0]    i_divisor,
    output logic [psr_pkg::QUO_W-1:0]    o_quotient
);
    import psr_pkg::*;

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_sub;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[QUO_W-1]};
        w_sub   = w_trial - {1'b0, i_divisor};
        w_ge    = w_trial >= {1'b0, i_divisor};
        n_rem   = w_ge ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_quo   = {r_quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_dividend[PROD_W-1:QUO_W];
            r_quo <= i_dividend[QUO_W-1:0];
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;

endmodule

// ===== sv/psr_ctrl.sv =====
// Sequencer for the pump speed ramp controller: handshakes and datapath commands.
// Depends on psr_pkg for the state type and command struct.
module psr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output psr_pkg::t_cmd o_cmd
);
    import psr_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_last_step;
    logic             w_commit;

    assign w_last_step = r_cnt == CNT_W'(DIV_STEPS - 1);
    assign w_commit    = (r_state == ST_FINISH) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_s_tvalid) n_state = ST_PREP;
            ST_PREP:    n_state = ST_MUL_DAC;
            ST_MUL_DAC: n_state = ST_DIV_DAC;
            ST_DIV_DAC: if (w_last_step) n_state = ST_MUL_PCT;
            ST_MUL_PCT: n_state = ST_DIV_PCT;
            ST_DIV_PCT: if (w_last_step) n_state = ST_FINISH;
            ST_FINISH:  if (w_commit) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = r_state == ST_IDLE;
        o_cmd          = '0;
        o_cmd.load     = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.prep     = r_state == ST_PREP;
        o_cmd.mul_dac  = r_state == ST_MUL_DAC;
        o_cmd.mul_pct  = r_state == ST_MUL_PCT;
        o_cmd.div_step = (r_state == ST_DIV_DAC) || (r_state == ST_DIV_PCT);
        o_cmd.commit   = w_commit;
        n_cnt          = (o_cmd.div_step && !w_last_step) ? r_cnt + 1'b1 : '0;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef ASSERT_OFF
    a_accept_starts_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_PREP))
        else $error("accepted request did not start preparation");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_FINISH))
        else $error("result valid raised outside finish");

    a_cnt_clear_outside_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_DAC || r_state == ST_MUL_PCT) |-> (r_cnt == '0))
        else $error("divide step counter not cleared");
`endif

endmodule

// ===== sv/psr_dp.sv =====
// Datapath: configuration registers, temperature ramp, drive stepping, arming and flow.
// Depends on psr_pkg and instantiates psr_div.
module psr_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  psr_pkg::t_cmd                      i_cmd,
    input  logic [psr_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic                               i_cfg_we,
    input  logic [psr_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [psr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic [psr_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import psr_pkg::*;

    function automatic logic [TGT_W-1:0] ramp_pick(
        input logic             lt,
        input logic             gt,
        input logic             eq,
        input logic             neg,
        input logic [TGT_W-1:0] yl,
        input logic [TGT_W-1:0] yh,
        input logic [TGT_W-1:0] q
    );
        if (lt) return yl;
        if (gt) return yh;
        if (eq) return yl;
        return neg ? yl - q : yl + q;
    endfunction

    logic [6:0]  r_spd_lo, r_spd_hi;
    logic [5:0]  r_tmp_lo, r_tmp_hi;
    logic [12:0] r_cur_lim;
    logic [15:0] r_arm_dly;

    logic [15:0] r_temp;
    logic [11:0] r_cur;
    logic [7:0]  r_pulses;
    logic [31:0] r_now;
    logic        r_en;

    logic             r_lt, r_gt, r_eq, r_neg;
    logic [DEN_W-1:0] r_diff, r_den;
    logic [PCT_W-1:0] r_pl, r_ph;
    logic [TGT_W-1:0] r_dac_l, r_dac_h, r_target;
    logic [31:0]      r_deadline;
    logic             r_was_en, r_armed;
    logic [15:0]      r_pulse_total;

    logic [DAC_BITS-1:0] r_drive, n_drive;
    logic [PCT_W-1:0]    r_o_pct;
    logic                r_o_cf, r_o_tf;
    logic [FLOW_W-1:0]   r_last_flow;

    logic [DEN_W-1:0]   w_xl, w_xh;
    logic [EXT_W-1:0]   w_t17, w_xl17, w_xh17, w_diff17;
    logic [PCT_W-1:0]   w_pl, w_ph;
    logic [31:0]        w_deadline;
    logic [16:0]        w_psum;
    logic               w_dac_neg, w_pct_neg, w_mul_neg;
    logic [TGT_W-1:0]   w_dac_mag, w_pct_mag, w_mul_mag;
    logic [PROD_W-1:0]  w_prod;
    logic [QUO_W-1:0]   w_quo;
    logic [TGT_W-1:0]   w_pct_full;
    logic [EXT_W-1:0]   w_drv_ext, w_tgt_ext;
    logic [FLOW_FULL_W-1:0] w_flow_full;
    logic [FLOW_W-1:0]  w_flow;
    logic               w_cf;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_lo  <= SPEED_LOW_RST;
            r_spd_hi  <= SPEED_HIGH_RST;
            r_tmp_lo  <= TEMP_LOW_RST;
            r_tmp_hi  <= TEMP_HIGH_RST;
            r_cur_lim <= CUR_LIMIT_RST;
            r_arm_dly <= ARM_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SPEED_LOW:  r_spd_lo  <= i_cfg_wdata[6:0];
                CFG_SPEED_HIGH: r_spd_hi  <= i_cfg_wdata[6:0];
                CFG_TEMP_LOW:   r_tmp_lo  <= i_cfg_wdata[5:0];
                CFG_TEMP_HIGH:  r_tmp_hi  <= i_cfg_wdata[5:0];
                CFG_CUR_LIMIT:  r_cur_lim <= i_cfg_wdata[12:0];
                CFG_ARM_DELAY:  r_arm_dly <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_temp   <= i_s_tdata[15:0];
            r_cur    <= i_s_tdata[27:16];
            r_pulses <= i_s_tdata[35:28];
            r_now    <= i_s_tdata[67:36];
            r_en     <= i_s_tdata[68];
        end
    end

    // ramp setup and arming
    always_comb begin
        w_xl     = DEN_W'({7'b0, r_tmp_lo} * DEG_SCALE);
        w_xh     = DEN_W'({7'b0, r_tmp_hi} * DEG_SCALE);
        w_t17    = {r_temp[15], r_temp};
        w_xl17   = {4'b0, w_xl};
        w_xh17   = {4'b0, w_xh};
        w_diff17 = w_t17 - w_xl17;
        w_pl     = (r_spd_lo > PCT_LIMIT) ? PCT_LIMIT : r_spd_lo;
        w_ph     = (r_spd_hi > PCT_LIMIT) ? PCT_LIMIT : r_spd_hi;
        w_deadline = (r_en && !r_was_en) ? r_now + {16'b0, r_arm_dly} : r_deadline;
        w_psum   = {1'b0, r_pulse_total} + {9'b0, r_pulses};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_lt    <= $signed(w_t17) < $signed(w_xl17);
            r_gt    <= $signed(w_t17) > $signed(w_xh17);
            r_eq    <= w_xl == w_xh;
            r_diff  <= w_diff17[DEN_W-1:0];
            r_den   <= w_xh - w_xl;
            r_pl    <= w_pl;
            r_ph    <= w_ph;
            r_dac_l <= PCT_TO_DAC[w_pl];
            r_dac_h <= PCT_TO_DAC[w_ph];
            r_armed <= r_now > w_deadline;
        end
    end

    // interpolation: magnitude product into the divider
    always_comb begin
        w_dac_neg = r_dac_h < r_dac_l;
        w_dac_mag = w_dac_neg ? r_dac_l - r_dac_h : r_dac_h - r_dac_l;
        w_pct_neg = r_ph < r_pl;
        w_pct_mag = w_pct_neg ? TGT_W'(r_pl - r_ph) : TGT_W'(r_ph - r_pl);
        w_mul_neg = i_cmd.mul_pct ? w_pct_neg : w_dac_neg;
        w_mul_mag = i_cmd.mul_pct ? w_pct_mag : w_dac_mag;
        w_prod    = {{(PROD_W-DEN_W){1'b0}}, r_diff} * {{(PROD_W-TGT_W){1'b0}}, w_mul_mag};
    end

    psr_div u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.mul_dac | i_cmd.mul_pct),
        .i_step     (i_cmd.div_step),
        .i_dividend (w_prod),
        .i_divisor  (r_den),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_dac || i_cmd.mul_pct) begin
            r_neg <= w_mul_neg;
        end
        if (i_cmd.mul_pct) begin
            r_target <= ramp_pick(r_lt, r_gt, r_eq, r_neg, r_dac_l, r_dac_h, w_quo);
        end
    end

    // result and state update
    always_comb begin
        w_pct_full = ramp_pick(r_lt, r_gt, r_eq, r_neg, {5'b0, r_pl}, {5'b0, r_ph}, w_quo);
        w_drv_ext  = EXT_W'(r_drive);
        w_tgt_ext  = EXT_W'(r_target);
        if (!r_en) begin
            n_drive = '0;
        end else if (w_drv_ext < w_tgt_ext) begin
            n_drive = (r_drive != DAC_MAX) ? r_drive + 1'b1 : r_drive;
        end else begin
            n_drive = (r_drive != '0) ? r_drive - 1'b1 : r_drive;
        end
        w_flow_full = FLOW_FULL_W'(r_pulse_total) * FLOW_PER_PULSE;
        w_flow      = (w_flow_full > FLOW_FULL_W'(FLOW_MAX)) ? FLOW_MAX
                                                             : w_flow_full[FLOW_W-1:0];
        w_cf        = (r_cur_lim != '0) && ({1'b0, r_cur} > r_cur_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive       <= '0;
            r_deadline    <= {16'b0, ARM_DELAY_RST};
            r_was_en      <= 1'b1;
            r_pulse_total <= '0;
            r_last_flow   <= '0;
        end else if (i_cmd.prep) begin
            r_deadline    <= w_deadline;
            r_was_en      <= r_en;
            r_pulse_total <= w_psum[16] ? 16'hFFFF : w_psum[15:0];
        end else if (i_cmd.commit) begin
            r_drive <= n_drive;
            if (r_armed) begin
                r_last_flow   <= w_flow;
                r_pulse_total <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_pct <= w_pct_full[PCT_W-1:0];
            r_o_cf  <= r_armed & w_cf;
            r_o_tf  <= r_armed & (r_pulse_total == '0);
        end
    end

    assign o_m_tdata = {1'b0, r_last_flow, r_o_tf, r_o_cf, r_o_pct, w_drv_ext[11:0]};

`ifndef ASSERT_OFF
    a_faults_need_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_armed) |=> (!r_o_cf && !r_o_tf))
        else $error("fault flagged while not armed");

    a_drive_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive != $past(r_drive)) |-> ($past(i_cmd.commit) || !$past(i_rst_n)))
        else $error("drive level changed outside commit");

    a_flow_on_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_armed) |=> $stable(r_last_flow))
        else $error("flow changed on unarmed poll");
`endif

endmodule

// ===== sv/pump_speed_ramp_controller.sv =====
// Pump speed ramp controller, top level: joins the sequencer and the datapath.
// Depends on psr_pkg, psr_ctrl, psr_dp (and psr_div below it).
//
// Usage: one request per poll on the slave stream carries temperature, pump
// current, tacho pulses, millisecond time and enable; one result per request
// leaves on the master stream with the drive value, ramp percent, the two fault
// flags and the flow figure. Registers must be written on the plain write port
// only while no request is in flight; the block itself does not enforce this.
// Sequencing: an accepted request passes through preparation, the drive target
// multiply and divide, the percent multiply and divide, and a finish step that
// loads the result; the next request is taken only after that. The shared
// restoring divider runs 12 steps for the drive target and 12 more for percent.
// Reset (synchronous, active low) returns registers to their defaults, clears
// the drive level, pulse count and flow, and marks enable as previously high.
// When the receiver stalls, the result is held in the output register; the
// next request may still be accepted, and its result waits in the final step
// until the output register is free.
module pump_speed_ramp_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [15:0] coolant_temp, [27:16] pump_current, [35:28] tacho_pulses,
    // [67:36] time_ms, [68] enable, [71:69] zero
    input  logic [psr_pkg::S_TDATA_W-1:0]      i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [11:0] dac_value, [18:12] speed_pct, [19] current_fault,
    // [20] tacho_fault, [38:21] flow_raw, [39] zero
    output logic [psr_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [psr_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [psr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import psr_pkg::*;

    t_cmd w_cmd;

    psr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    psr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pump_speed_ramp_controller: a scoreboard class
// predicts each status from the polls it accepts. Depends on psr_pkg and the RTL.
module testbench;
    import psr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 40;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic        enable;
        logic [31:0] time_ms;
        logic [7:0]  tacho_pulses;
        logic [11:0] pump_current;
        logic [15:0] coolant_temp;
    } poll_t;

    typedef struct packed {
        logic [17:0] flow_raw;
        logic        tacho_fault;
        logic        current_fault;
        logic [6:0]  speed_pct;
        logic [11:0] dac_value;
    } status_t;

    typedef struct {
        int speed_low;
        int speed_high;
        int temp_low;
        int temp_high;
        int cur_limit;
        int arm_delay;
    } reg_set_t;

    class drive_checker;
        status_t     expected_status[$];
        int          mismatches;
        int          checked;
        logic [6:0]  speed_low, speed_high;
        logic [5:0]  temp_low, temp_high;
        logic [12:0] cur_limit;
        logic [15:0] arm_delay;
        logic [11:0] drive_level;
        logic [31:0] arm_deadline;
        bit          was_enabled;
        int          pulse_total;
        logic [17:0] last_flow;

        function new();
            speed_low = 20;
            speed_high = 50;
            temp_low = 25;
            temp_high = 40;
            cur_limit = 0;
            arm_delay = 3000;
            drive_level = 0;
            arm_deadline = 3000;
            was_enabled = 1;
            pulse_total = 0;
            last_flow = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [15:0] data);
            case (addr)
                CFG_SPEED_LOW:  speed_low = data[6:0];
                CFG_SPEED_HIGH: speed_high = data[6:0];
                CFG_TEMP_LOW:   temp_low = data[5:0];
                CFG_TEMP_HIGH:  temp_high = data[5:0];
                CFG_CUR_LIMIT:  cur_limit = data[12:0];
                CFG_ARM_DELAY:  arm_delay = data;
                default: ;
            endcase
        endfunction

        function longint ramp(longint t, longint xl, longint xh, longint yl, longint yh);
            if (t < xl) return yl;
            if (t > xh) return yh;
            if (xh == xl) return yl;
            return yl + ((t - xl) * (yh - yl)) / (xh - xl);
        endfunction

        function status_t predict_status(poll_t p);
            status_t s;
            longint  t, xl, xh, tgt, pct;
            int      pl, ph, flow;
            t = longint'($signed(p.coolant_temp));
            xl = longint'(temp_low) * 100;
            xh = longint'(temp_high) * 100;
            pl = (speed_low > 100) ? 100 : int'(speed_low);
            ph = (speed_high > 100) ? 100 : int'(speed_high);
            tgt = ramp(t, xl, xh, pl * 4095 / 100, ph * 4095 / 100);
            pct = ramp(t, xl, xh, pl, ph);
            if (p.enable && !was_enabled)
                arm_deadline = p.time_ms + 32'(arm_delay);
            was_enabled = p.enable;
            if (p.enable) begin
                if (int'(drive_level) < tgt) begin
                    if (drive_level != 12'hFFF) drive_level = drive_level + 1;
                end else if (drive_level != 0) begin
                    drive_level = drive_level - 1;
                end
            end else begin
                drive_level = 0;
            end
            pulse_total = pulse_total + p.tacho_pulses;
            if (pulse_total > 65535) pulse_total = 65535;
            s = '0;
            if (p.time_ms > arm_deadline) begin
                s.current_fault = (cur_limit != 0) && (p.pump_current > cur_limit);
                s.tacho_fault = (pulse_total == 0);
                flow = pulse_total * 600;
                last_flow = (flow > 262143) ? 18'h3FFFF : 18'(flow);
                pulse_total = 0;
            end
            s.dac_value = drive_level;
            s.speed_pct = 7'(pct);
            s.flow_raw = last_flow;
            return s;
        endfunction

        function void note_poll(poll_t p);
            expected_status.push_back(predict_status(p));
        endfunction

        function void flag(string field, longint want, longint got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch in %s: expected %0d, got %0d",
                         $realtime, field, want, got);
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: status %h with no request outstanding", $realtime, got);
                return;
            end
            want = expected_status.pop_front();
            checked++;
            if (got.dac_value !== want.dac_value)
                flag("dac_value", want.dac_value, got.dac_value);
            if (got.speed_pct !== want.speed_pct)
                flag("speed_pct", want.speed_pct, got.speed_pct);
            if (got.current_fault !== want.current_fault)
                flag("current_fault", want.current_fault, got.current_fault);
            if (got.tacho_fault !== want.tacho_fault)
                flag("tacho_fault", want.tacho_fault, got.tacho_fault);
            if (got.flow_raw !== want.flow_raw)
                flag("flow_raw", want.flow_raw, got.flow_raw);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    drive_checker board = new();
    logic [31:0]  now_ms;
    bit           en_state;
    int           burst_left;
    int           polls_sent;
    int           settings_done;

    pump_speed_ramp_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** pump_speed_ramp_controller: FAILED **");
        $finish;
    end

    initial begin
        int  mode;
        int  run_left;
        bit  level;
        mode = 0;
        run_left = 0;
        level = 1'b1;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                board.check_status(status_t'(o_m_tdata[38:0]));
            if (run_left == 0) begin
                if ($urandom_range(0, 7) == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: begin
                        level = 1'b1;
                        run_left = $urandom_range(20, 100);
                    end
                    1: begin
                        level = ($urandom_range(0, 3) != 0);
                        run_left = $urandom_range(1, 3);
                    end
                    2: begin
                        level = ($urandom_range(0, 3) == 0);
                        run_left = $urandom_range(1, 4);
                    end
                    default: begin
                        level = !level;
                        run_left = $urandom_range(1, 60);
                    end
                endcase
            end
            run_left--;
            i_m_tready <= level;
        end
    end

    task automatic send_poll(input poll_t p);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {3'b000, p};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_poll(p);
        polls_sent++;
    endtask

    task automatic poll(input int temp, input int cur, input int tacho,
                        input logic [31:0] ms, input bit en);
        poll_t p;
        p.coolant_temp = 16'(temp);
        p.pump_current = 12'(cur);
        p.tacho_pulses = 8'(tacho);
        p.time_ms = ms;
        p.enable = en;
        send_poll(p);
    endtask

    // drop valid and idle, optionally until every status is back
    task automatic hold_off(input int n, input bit drain);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        repeat (n) @(posedge i_clk);
        if (drain) begin
            while (board.pending() != 0) @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input int val,
                             input int width);
        logic [15:0] wd;
        wd = 16'(val);
        if (width < 16 && $urandom_range(0, 1) == 1)
            wd = wd | (16'($urandom) << width);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= wd;
        @(posedge i_clk);
        board.write_reg(addr, wd);
    endtask

    task automatic set_config(input reg_set_t s);
        cfg_write(CFG_SPEED_LOW, s.speed_low, 7);
        cfg_write(CFG_SPEED_HIGH, s.speed_high, 7);
        cfg_write(CFG_TEMP_LOW, s.temp_low, 6);
        cfg_write(CFG_TEMP_HIGH, s.temp_high, 6);
        cfg_write(CFG_CUR_LIMIT, s.cur_limit, 13);
        cfg_write(CFG_ARM_DELAY, s.arm_delay, 16);
        cfg_write(CFG_SPARE_A, $urandom, 0);
        cfg_write(CFG_SPARE_B, $urandom, 0);
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    task automatic run_phase(input reg_set_t s, input int count, input bit flood);
        poll_t p;
        int    drain_at, r, xl, xh, lo, hi, c;
        drain_at = $urandom_range(count / 4, 3 * count / 4);
        xl = (s.temp_low & 63) * 100;
        xh = (s.temp_high & 63) * 100;
        lo = ((xl < xh) ? xl : xh) - 300;
        hi = ((xl > xh) ? xl : xh) + 300;
        for (int n = 0; n < count; n++) begin
            if (n == drain_at) begin
                hold_off(0, 1);
            end else if (burst_left <= 0) begin
                if ($urandom_range(0, 3) != 0) hold_off($urandom_range(0, 35), 0);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;

            if (n == 0) en_state = 1'b0;
            else if (n == 1) en_state = 1'b1;
            else if (!flood && $urandom_range(0, 15) == 0) en_state = !en_state;

            r = $urandom_range(0, 99);
            if (flood) begin
                if (n >= count - 5) now_ms = now_ms + 70000;
            end else if (r < 70) begin
                now_ms = now_ms + $urandom_range(0, 4);
            end else if (r < 90) begin
                now_ms = now_ms + $urandom_range(5, 3000);
            end else if (r < 95) begin
                now_ms = $urandom;
            end else begin
                now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
            end

            r = $urandom_range(0, 99);
            if (r < 40) begin
                case ($urandom_range(0, 5))
                    0: c = xl - 1;
                    1: c = xl;
                    2: c = xl + 1;
                    3: c = xh - 1;
                    4: c = xh;
                    default: c = xh + 1;
                endcase
                p.coolant_temp = 16'(c);
            end else if (r < 85) begin
                p.coolant_temp = 16'(lo + int'($urandom_range(0, hi - lo)));
            end else begin
                p.coolant_temp = 16'($urandom);
            end

            if ($urandom_range(0, 6) == 0) begin
                c = (s.cur_limit & 8191) + int'($urandom_range(0, 2)) - 1;
                if (c > 4095) c = 4095;
                if (c < 0) c = 0;
                p.pump_current = 12'(c);
            end else begin
                p.pump_current = 12'($urandom_range(0, 4095));
            end

            r = $urandom_range(0, 99);
            if (flood) p.tacho_pulses = (r < 90) ? 8'hFF : 8'h00;
            else if (r < 30) p.tacho_pulses = 8'h00;
            else if (r < 40) p.tacho_pulses = 8'hFF;
            else p.tacho_pulses = 8'($urandom_range(1, 254));

            p.time_ms = now_ms;
            p.enable = en_state;
            send_poll(p);
        end
    endtask

    initial begin
        reg_set_t s;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_wdata <= '0;
        now_ms = 1000;
        en_state = 1'b1;
        burst_left = 0;
        polls_sent = 0;
        settings_done = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, arming on the reset deadline
        poll(2500, 0, 3, 10, 1);
        poll(4000, 4095, 0, 2999, 1);
        poll(3250, 4095, 0, 3001, 1);
        poll(-100, 1, 9, 3002, 1);

        hold_off(0, 1);
        s = '{10, 90, 25, 40, 2000, 5};
        set_config(s);
        poll(-32768, 0, 0, 100, 0);
        poll(32767, 4095, 255, 101, 1);
        poll(2500, 2001, 0, 106, 1);
        poll(4000, 2000, 0, 107, 1);
        poll(3250, 2001, 0, 108, 1);
        poll(2499, 12'hAAA, 8'hAA, 109, 1);
        poll(4001, 12'h555, 8'h55, 110, 1);
        poll(0, 0, 0, 32'hFFFF_FFFF, 0);
        poll(3999, 100, 7, 32'hFFFF_FFFE, 1);
        poll(-1, 3000, 0, 2, 1);

        // equal points, upper percent above 100
        hold_off(0, 1);
        s = '{30, 127, 30, 30, 0, 0};
        set_config(s);
        poll(2999, 10, 1, 200, 1);
        poll(3000, 10, 1, 201, 1);
        poll(3001, 10, 1, 202, 1);

        // crossed points
        hold_off(0, 1);
        s = '{60, 10, 40, 20, 4095, 0};
        set_config(s);
        poll(3999, 4095, 0, 300, 1);
        poll(4000, 4095, 0, 301, 1);
        poll(2000, 4095, 0, 302, 1);

        for (int ph = 0; ph < 10; ph++) begin
            hold_off(0, 1);
            s.speed_low = $urandom_range(0, 127);
            s.speed_high = $urandom_range(0, 127);
            s.cur_limit = $urandom_range(0, 8191);
            s.arm_delay = $urandom_range(0, 20);
            case (ph % 5)
                0: begin
                    s.speed_low = $urandom_range(5, 95);
                    s.speed_high = $urandom_range(5, 95);
                    s.temp_low = $urandom_range(0, 49);
                    s.temp_high = $urandom_range(s.temp_low + 1, 50);
                    s.cur_limit = $urandom_range(0, 5119);
                end
                1: begin
                    s.temp_low = $urandom_range(0, 63);
                    s.temp_high = s.temp_low;
                end
                2: begin
                    s.temp_low = $urandom_range(1, 63);
                    s.temp_high = $urandom_range(0, s.temp_low - 1);
                end
                3: begin
                    if (ph < 5) s = '{0, 0, 0, 0, 0, 0};
                    else s = '{127, 127, 63, 63, 8191, 65535};
                end
                default: begin
                    s.speed_low = $urandom_range(101, 127);
                    s.temp_low = $urandom_range(0, 40);
                    s.temp_high = $urandom_range(s.temp_low, 63);
                end
            endcase
            set_config(s);
            run_phase(s, 120, 0);
        end

        // freeze time behind a long arming delay to saturate the pulse count
        hold_off(0, 1);
        s = '{127, 0, 63, 0, 1, 65535};
        set_config(s);
        run_phase(s, 320, 1);

        hold_off(0, 1);
        $display("Sent %0d polls under %0d register settings, checked %0d statuses.",
                 polls_sent, settings_done, board.checked);
        $display("Ramp ends, equal and crossed points, percent clamp, arming, faults, flow.");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** pump_speed_ramp_controller: PASSED **");
        end else begin
            $display("** pump_speed_ramp_controller: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/psr_pkg.sv
sv/psr_div.sv
sv/psr_ctrl.sv
sv/psr_dp.sv
sv/pump_speed_ramp_controller.sv
tb/testbench.sv
